### sv/body_mask_compositor_defines.svh
// ---------------------------------------------------------------------------
// body_mask_compositor_defines.svh
// Assertion macros for the body mask compositor. Empty when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef BODY_MASK_COMPOSITOR_DEFINES_SVH
`define BODY_MASK_COMPOSITOR_DEFINES_SVH

`ifndef SYNTH
// plain property, sampled on i_clk, off while reset is low
`define BMC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("body_mask_compositor: check failed");
// cause in one cycle, effect in the next
`define BMC_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("body_mask_compositor: check failed");
`else
`define BMC_ASSERT(lbl, prop)
`define BMC_IMPLY(lbl, ante, cons)
`endif

`endif

### sv/bmc_pkg.sv
// ---------------------------------------------------------------------------
// bmc_pkg
// Shared constants and types of the body mask compositor.
// ---------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

    localparam int BODY_STORE_DEPTH_DEF = 262144;
    // wide enough for any store depth up to 2**20 and any frame address
    localparam int ADDR_CMP_W = 21;

    localparam logic CMD_LOAD      = 1'b0;
    localparam logic CMD_COMPOSITE = 1'b1;

    localparam logic [1:0] REG_DEPTH_COLS     = 2'd0;
    localparam logic [1:0] REG_DEPTH_ROWS     = 2'd1;
    localparam logic [1:0] REG_OVERLAY_ENABLE = 2'd2;
    localparam logic [1:0] REG_OVERLAY_SCALE  = 2'd3;

    localparam logic [9:0]  COLS_RESET  = 10'd512;
    localparam logic [9:0]  ROWS_RESET  = 10'd424;
    localparam logic [15:0] SCALE_RESET = 16'd256;

    // 255 * 256: full scale of alpha times Q8.8 scale
    localparam logic [15:0] BLEND_FULL  = 16'd65280;
    localparam logic [15:0] BLEND_HALF  = 16'd32640;
    localparam logic [15:0] SCALE_ONE   = 16'd256;
    localparam logic [15:0] SCALE_MIN   = 16'd2;
    localparam logic [7:0]  PERSON_MAX  = 8'd5;
    // floor(2**23 / 255)
    localparam logic [15:0] RECIP_255   = 16'd32896;

    typedef struct packed {
        logic        busy;
        logic [7:0]  quo;
        logic [15:0] rem;
    } t_div_res;

endpackage

`default_nettype wire

### sv/bmc_scale_div.sv
// ---------------------------------------------------------------------------
// bmc_scale_div
// Restoring divider for 65280 / scale, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bmc_scale_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [15:0]       i_divisor,
    output bmc_pkg::t_div_res      o_res
);

    // divisor is at least 256, so the quotient has 8 bits
    localparam logic [3:0] DIV_STEPS = 4'd8;

    logic [3:0]  r_cnt;
    logic [15:0] r_den;
    logic [15:0] r_rem;
    logic [7:0]  r_quo;

    logic [2:0]  bit_idx;
    logic [16:0] shifted;
    logic [16:0] diff;
    logic        ge;

    assign bit_idx = 3'(r_cnt - 4'd1);
    assign shifted = {r_rem, bmc_pkg::BLEND_FULL[bit_idx]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_den <= bmc_pkg::SCALE_RESET;
            // reset scale is 1.0: 65280 / 256 = 255 remainder 0
            r_rem <= '0;
            r_quo <= 8'hFF;
        end else if (i_start) begin
            r_cnt <= DIV_STEPS;
            r_den <= i_divisor;
            r_rem <= {8'd0, bmc_pkg::BLEND_FULL[15:8]};
            r_quo <= '0;
        end else if (r_cnt != 4'd0) begin
            r_rem <= ge ? diff[15:0] : shifted[15:0];
            r_quo <= {r_quo[6:0], ge};
            r_cnt <= r_cnt - 4'd1;
        end
    end

    assign o_res.busy = (r_cnt != 4'd0);
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

`default_nettype wire

### sv/bmc_body_store.sv
// ---------------------------------------------------------------------------
// bmc_body_store
// Single-port body-index memory, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bmc_body_store #(
    parameter int DEPTH = bmc_pkg::BODY_STORE_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [7:0]               i_wdata,
    output logic [7:0]                    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/body_mask_compositor.sv
// ---------------------------------------------------------------------------
// body_mask_compositor
// Person-mask background replacement with an optional alpha overlay.
// ---------------------------------------------------------------------------
//  port group   dir  beat contents
//  s_axis       in   load (tuser 0) or composite (tuser 1) item
//  m_axis       out  composited BGR pixel, tuser = is_person
//  apb          in   depth_cols, depth_rows, overlay_enable, overlay_scale
//
//  One item per clock unless m_axis or divider stalls; every stage is registered.
//  Loads write the store in the cycle after acceptance and return nothing.
//  The store is not cleared at reset; entries are undefined until loaded.
//  A write to overlay_scale runs an 8-step divider for 65280/max(scale,1.0);
//  the slave side drops tready from its start strobe until it finishes.
//  Each stage has its own valid bit, so bubbles close up under m_axis stalls.
// ---------------------------------------------------------------------------
`default_nettype none
`include "body_mask_compositor_defines.svh"

module body_mask_compositor #(
    parameter int BODY_STORE_DEPTH = bmc_pkg::BODY_STORE_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // s_axis
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // load_address[17:0], body_label[25:18], map_x[41:26], map_y[57:42],
    // camera_pixel[81:58], background_pixel[105:82], overlay_pixel[137:106]
    input  wire logic [143:0] i_s_axis_tdata,
    // command
    input  wire logic         i_s_axis_tuser,
    // m_axis
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // out_pixel[23:0]
    output logic [23:0]       o_m_axis_tdata,
    // is_person
    output logic              o_m_axis_tuser,
    // apb
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int STORE_AW = $clog2(BODY_STORE_DEPTH);
    localparam int CW       = bmc_pkg::ADDR_CMP_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(BODY_STORE_DEPTH);

    // ---------------- configuration ----------------
    logic [9:0]  r_cols;
    logic [9:0]  r_rows;
    logic        r_ovl_en;
    logic [15:0] r_scale;
    logic        r_div_start;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic [15:0] seff;
    bmc_pkg::t_div_res div_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols      <= bmc_pkg::COLS_RESET;
            r_rows      <= bmc_pkg::ROWS_RESET;
            r_ovl_en    <= 1'b0;
            r_scale     <= bmc_pkg::SCALE_RESET;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= cfg_wr && (cfg_idx == bmc_pkg::REG_OVERLAY_SCALE);
            if (cfg_wr) begin
                case (cfg_idx)
                    bmc_pkg::REG_DEPTH_COLS:     r_cols   <= pwdata[9:0];
                    bmc_pkg::REG_DEPTH_ROWS:     r_rows   <= pwdata[9:0];
                    bmc_pkg::REG_OVERLAY_ENABLE: r_ovl_en <= pwdata[0];
                    bmc_pkg::REG_OVERLAY_SCALE:  r_scale  <= pwdata[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (cfg_idx)
            bmc_pkg::REG_DEPTH_COLS:     prdata = {22'd0, r_cols};
            bmc_pkg::REG_DEPTH_ROWS:     prdata = {22'd0, r_rows};
            bmc_pkg::REG_OVERLAY_ENABLE: prdata = {31'd0, r_ovl_en};
            bmc_pkg::REG_OVERLAY_SCALE:  prdata = {16'd0, r_scale};
            default:                     prdata = '0;
        endcase
    end

    // scales below 1.0 are folded into alpha, then act as 1.0
    assign seff = (r_scale < bmc_pkg::SCALE_ONE) ? bmc_pkg::SCALE_ONE : r_scale;

    bmc_scale_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_divisor (seff),
        .o_res     (div_res)
    );

    // ---------------- stage ready chain ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_vo;
    logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7, rdy_s8, rdy_out;
    logic r_s1_cmd;
    logic accept_in;

    assign rdy_out = !r_vo || i_m_axis_tready;
    assign rdy_s8  = !r_v8 || rdy_out;
    assign rdy_s7  = !r_v7 || rdy_s8;
    assign rdy_s6  = !r_v6 || rdy_s7;
    assign rdy_s5  = !r_v5 || rdy_s6;
    assign rdy_s4  = !r_v4 || rdy_s5;
    assign rdy_s3  = !r_v3 || rdy_s4;
    assign rdy_s2  = !r_v2 || rdy_s3;
    // a load leaves stage 1 without waiting for stage 2
    assign rdy_s1  = !r_v1 || (r_s1_cmd == bmc_pkg::CMD_LOAD) || rdy_s2;

    assign o_s_axis_tready = rdy_s1 && !r_div_start && !div_res.busy;
    assign accept_in       = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- stage 0: frame address ----------------
    logic [15:0] in_x, in_y;
    logic [10:0] in_col, in_row;
    logic        in_frame;
    logic [19:0] prod_rc;
    logic [19:0] in_addr;

    assign in_x     = i_s_axis_tdata[41:26];
    assign in_y     = i_s_axis_tdata[57:42];
    assign in_col   = in_x[14:4];
    assign in_row   = in_y[14:4];
    assign in_frame = !in_x[15] && !in_y[15] &&
                      (in_col < {1'b0, r_cols}) && (in_row < {1'b0, r_rows});
    assign prod_rc  = {10'd0, in_row[9:0]} * {10'd0, r_cols};
    assign in_addr  = prod_rc + {10'd0, in_col[9:0]};

    logic [17:0] r_s1_ldaddr;
    logic [7:0]  r_s1_label;
    logic        r_s1_frame;
    logic [19:0] r_s1_addr;
    logic [23:0] r_s1_cam, r_s1_bg;
    logic [31:0] r_s1_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy_s1) begin
            r_v1 <= accept_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_s1_cmd    <= i_s_axis_tuser;
            r_s1_ldaddr <= i_s_axis_tdata[17:0];
            r_s1_label  <= i_s_axis_tdata[25:18];
            r_s1_frame  <= in_frame;
            r_s1_addr   <= in_addr;
            r_s1_cam    <= i_s_axis_tdata[81:58];
            r_s1_bg     <= i_s_axis_tdata[105:82];
            r_s1_ovl    <= i_s_axis_tdata[137:106];
        end
    end

    // ---------------- stage 1: store access ----------------
    logic [CW-1:0]       ld_ext, cx_ext;
    logic                store_we, store_re;
    logic [STORE_AW-1:0] store_addr;
    logic [7:0]          store_rdata;

    assign ld_ext     = {{(CW-18){1'b0}}, r_s1_ldaddr};
    assign cx_ext     = {{(CW-20){1'b0}}, r_s1_addr};
    assign store_we   = r_v1 && (r_s1_cmd == bmc_pkg::CMD_LOAD) && (ld_ext < DEPTH_C);
    assign store_re   = r_v1 && (r_s1_cmd == bmc_pkg::CMD_COMPOSITE) && rdy_s2;
    assign store_addr = (r_s1_cmd == bmc_pkg::CMD_LOAD) ? ld_ext[STORE_AW-1:0]
                                                        : cx_ext[STORE_AW-1:0];

    bmc_body_store #(
        .DEPTH (BODY_STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_re    (store_re),
        .i_addr  (store_addr),
        .i_wdata (r_s1_label),
        .o_rdata (store_rdata)
    );

    logic        r_s2_ok;
    logic [23:0] r_s2_cam, r_s2_bg;
    logic [31:0] r_s2_ovl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy_s2) begin
            r_v2 <= r_v1 && (r_s1_cmd == bmc_pkg::CMD_COMPOSITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s2) begin
            r_s2_ok  <= r_s1_frame && (cx_ext < DEPTH_C);
            r_s2_cam <= r_s1_cam;
            r_s2_bg  <= r_s1_bg;
            r_s2_ovl <= r_s1_ovl;
        end
    end

    // ---------------- stage 2: person decision, alpha * scale ----------------
    logic        s2_person;
    logic [23:0] s2_as;

    assign s2_person = r_s2_ok && (store_rdata <= bmc_pkg::PERSON_MAX);
    assign s2_as     = {16'd0, r_s2_ovl[31:24]} * {8'd0, r_scale};

    logic        r_s3_person;
    logic [23:0] r_s3_pix, r_s3_ovl, r_s3_as;
    logic [7:0]  r_s3_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy_s3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s3) begin
            r_s3_person <= s2_person;
            r_s3_pix    <= s2_person ? r_s2_cam : r_s2_bg;
            r_s3_ovl    <= r_s2_ovl[23:0];
            r_s3_as     <= s2_as;
            r_s3_alpha  <= r_s2_ovl[31:24];
        end
    end

    // ---------------- stage 3: effective alpha and background weight ----------------
    logic       as_up;
    logic [8:0] a_round;
    logic [7:0] n_alpha;
    logic [8:0] t_base;
    logic       t_zero, t_up;
    logic [16:0] two_r;
    logic [9:0] t_round;
    logic [7:0] n_t;

    // alpha * scale / 256, ties to even; only used for scales below 1.0
    assign as_up   = (r_s3_as[7:0] > 8'd128) ||
                     ((r_s3_as[7:0] == 8'd128) && r_s3_as[8]);
    assign a_round = {1'b0, r_s3_as[15:8]} + {8'd0, as_up};
    assign n_alpha = (r_scale < bmc_pkg::SCALE_ONE) ? a_round[7:0] : r_s3_alpha;

    // t = round(65280/S - a) from quotient and remainder of 65280/S
    assign t_base  = {1'b0, div_res.quo} - {1'b0, n_alpha};
    assign t_zero  = (n_alpha > div_res.quo) ||
                     ((n_alpha == div_res.quo) && (div_res.rem == 16'd0));
    assign two_r   = {div_res.rem, 1'b0};
    assign t_up    = (two_r > {1'b0, seff}) || ((two_r == {1'b0, seff}) && t_base[0]);
    assign t_round = {1'b0, t_base} + {9'd0, t_up};
    assign n_t     = t_zero ? 8'd0 : ((t_round > 10'd255) ? 8'hFF : t_round[7:0]);

    logic       r_s4_person;
    logic [23:0] r_s4_pix, r_s4_ovl;
    logic [7:0] r_s4_a, r_s4_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy_s4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s4) begin
            r_s4_person <= r_s3_person;
            r_s4_pix    <= r_s3_pix;
            r_s4_ovl    <= r_s3_ovl;
            r_s4_a      <= n_alpha;
            r_s4_t      <= n_t;
        end
    end

    // ---------------- stage 4: weights times scale ----------------
    logic        r_s5_person;
    logic [23:0] r_s5_pix, r_s5_ovl, r_s5_at, r_s5_tt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy_s5) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s5) begin
            r_s5_person <= r_s4_person;
            r_s5_pix    <= r_s4_pix;
            r_s5_ovl    <= r_s4_ovl;
            r_s5_at     <= {16'd0, r_s4_a} * {8'd0, seff};
            r_s5_tt     <= {16'd0, r_s4_t} * {8'd0, seff};
        end
    end

    // ---------------- stage 5: channel products ----------------
    // lanes 0..2: pixel channel * t*S, lanes 3..5: overlay channel * a*S
    logic [31:0] s5_prod [6];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            s5_prod[c]   = {24'd0, r_s5_pix[8*c +: 8]} * {8'd0, r_s5_tt};
            s5_prod[c+3] = {24'd0, r_s5_ovl[8*c +: 8]} * {8'd0, r_s5_at};
        end
    end

    logic        r_s6_person;
    logic [23:0] r_s6_pix;
    logic [31:0] r_s6_prod [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (rdy_s6) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s6) begin
            r_s6_person <= r_s5_person;
            r_s6_pix    <= r_s5_pix;
            r_s6_prod   <= s5_prod;
        end
    end

    // ---------------- stage 6: divide by 65280, reciprocal estimate ----------------
    // x / 65280 = (x >> 8) / 255 with the low byte kept for the remainder
    logic [39:0] s6_rcp [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            s6_rcp[i] = {16'd0, r_s6_prod[i][31:8]} * {24'd0, bmc_pkg::RECIP_255};
        end
    end

    logic        r_s7_person;
    logic [23:0] r_s7_pix;
    logic [16:0] r_s7_qe [6];
    logic [23:0] r_s7_hi [6];
    logic [7:0]  r_s7_lo [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (rdy_s7) begin
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s7) begin
            r_s7_person <= r_s6_person;
            r_s7_pix    <= r_s6_pix;
            for (int i = 0; i < 6; i++) begin
                r_s7_qe[i] <= s6_rcp[i][39:23];
                r_s7_hi[i] <= r_s6_prod[i][31:8];
                r_s7_lo[i] <= r_s6_prod[i][7:0];
            end
        end
    end

    // ---------------- stage 7: quotient correction ----------------
    // the estimate is low by at most one
    logic [24:0] s7_r   [6];
    logic        s7_fix [6];
    logic [24:0] s7_r1  [6];
    logic [16:0] n_q    [6];
    logic [15:0] n_rem  [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            s7_r[i]   = {1'b0, r_s7_hi[i]} - ({r_s7_qe[i], 8'd0} - {8'd0, r_s7_qe[i]});
            s7_fix[i] = (s7_r[i] >= 25'd255);
            s7_r1[i]  = s7_fix[i] ? (s7_r[i] - 25'd255) : s7_r[i];
            n_q[i]    = r_s7_qe[i] + {16'd0, s7_fix[i]};
            n_rem[i]  = {s7_r1[i][7:0], r_s7_lo[i]};
        end
    end

    logic        r_s8_person;
    logic [23:0] r_s8_pix;
    logic [16:0] r_s8_q   [6];
    logic [15:0] r_s8_rem [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (rdy_s8) begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s8) begin
            r_s8_person <= r_s7_person;
            r_s8_pix    <= r_s7_pix;
            r_s8_q      <= n_q;
            r_s8_rem    <= n_rem;
        end
    end

    // ---------------- stage 8: round, saturate, sum ----------------
    logic        rnd_up [6];
    logic [17:0] q_rnd  [6];
    logic [7:0]  q_sat  [6];
    logic [8:0]  ch_sum [3];
    logic [23:0] blend_pix;
    logic        do_blend;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            rnd_up[i] = (r_s8_rem[i] > bmc_pkg::BLEND_HALF) ||
                        ((r_s8_rem[i] == bmc_pkg::BLEND_HALF) && r_s8_q[i][0]);
            q_rnd[i]  = {1'b0, r_s8_q[i]} + {17'd0, rnd_up[i]};
            q_sat[i]  = (q_rnd[i] > 18'd255) ? 8'hFF : q_rnd[i][7:0];
        end
        for (int c = 0; c < 3; c++) begin
            ch_sum[c]          = {1'b0, q_sat[c]} + {1'b0, q_sat[c+3]};
            blend_pix[8*c +: 8] = ch_sum[c][8] ? 8'hFF : ch_sum[c][7:0];
        end
    end

    assign do_blend = r_ovl_en && (r_scale > bmc_pkg::SCALE_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (rdy_out) begin
            r_vo <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            o_m_axis_tdata <= do_blend ? blend_pix : r_s8_pix;
            o_m_axis_tuser <= r_s8_person;
        end
    end

    assign o_m_axis_tvalid = r_vo;

    // ---------------- checks ----------------
    `BMC_ASSERT(a_store_single_access, !(store_we && store_re))
    `BMC_IMPLY(a_read_lands_in_s2, store_re, r_v2)
    `BMC_ASSERT(a_div_full_length, $fell(div_res.busy) |-> $past(div_res.busy, 8))

endmodule

`default_nettype wire

### dv/body_mask_checker.sv
// ---------------------------------------------------------------------------
// body_mask_checker
// Watches the stream and APB ports of the body mask compositor. It keeps its
// own label store and register copy and predicts the pixel and person flag
// of every composite beat. Each output beat is compared with the oldest
// prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module body_mask_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    input  wire logic [143:0] i_s_tdata,
    input  wire logic         i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    input  wire logic [23:0]  i_m_tdata,
    input  wire logic         i_m_tuser,
    input  wire logic         i_psel,
    input  wire logic         i_penable,
    input  wire logic         i_pwrite,
    input  wire logic [3:0]   i_paddr,
    input  wire logic [31:0]  i_pwdata,
    input  wire logic         i_pready,
    output int                o_err_cnt,
    output int                o_pending
);

    typedef struct packed {
        logic [23:0] pixel;
        logic        person;
    } t_composite;

    logic [9:0]  cfg_cols;
    logic [9:0]  cfg_rows;
    logic        cfg_overlay_en;
    logic [15:0] cfg_scale;
    logic [7:0]  body_labels [0:bmc_pkg::BODY_STORE_DEPTH_DEF-1];
    t_composite  pixels_due [$];

    function automatic longint unsigned round_half_even(input longint unsigned num,
                                                        input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        if (2 * r > den || (2 * r == den && q[0]))
            q++;
        return q;
    endfunction

    function automatic logic [23:0] blend_overlay(input logic [23:0] base,
                                                  input logic [31:0] ovl);
        longint unsigned s, a, t, d, o, d1, d2, c;
        logic [23:0] mixed;
        s = cfg_scale;
        a = ovl[31:24];
        if (s <= bmc_pkg::SCALE_MIN)
            return base;
        // scale below 1.0 is folded into alpha
        if (s < bmc_pkg::SCALE_ONE) begin
            a = round_half_even(a * s, bmc_pkg::SCALE_ONE);
            if (a > 255)
                a = 255;
            s = bmc_pkg::SCALE_ONE;
        end
        if (a * s >= bmc_pkg::BLEND_FULL)
            t = 0;
        else begin
            t = round_half_even(bmc_pkg::BLEND_FULL - a * s, s);
            if (t > 255)
                t = 255;
        end
        for (int ch = 0; ch < 3; ch++) begin
            d = base[8*ch +: 8];
            o = ovl[8*ch +: 8];
            d1 = round_half_even(d * t * s, bmc_pkg::BLEND_FULL);
            d2 = round_half_even(o * a * s, bmc_pkg::BLEND_FULL);
            if (d1 > 255)
                d1 = 255;
            if (d2 > 255)
                d2 = 255;
            c = d1 + d2;
            if (c > 255)
                c = 255;
            mixed[8*ch +: 8] = c[7:0];
        end
        return mixed;
    endfunction

    function automatic t_composite predict_composite(input logic [143:0] beat);
        logic [15:0] mx, my;
        logic [10:0] col, row;
        int unsigned addr;
        t_composite  res;
        mx = beat[41:26];
        my = beat[57:42];
        res.person = 1'b0;
        // negative coordinates, the invalid mark included, are never a person
        if (!mx[15] && !my[15]) begin
            col = mx[14:4];
            row = my[14:4];
            if (col < cfg_cols && row < cfg_rows) begin
                addr = int'(row) * int'(cfg_cols) + int'(col);
                if (addr < bmc_pkg::BODY_STORE_DEPTH_DEF &&
                    body_labels[addr] <= bmc_pkg::PERSON_MAX)
                    res.person = 1'b1;
            end
        end
        res.pixel = res.person ? beat[81:58] : beat[105:82];
        if (cfg_overlay_en)
            res.pixel = blend_overlay(res.pixel, beat[137:106]);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] want,
                                   input logic [23:0] got);
        if (o_err_cnt < 200)
            $display("[%0t] %s mismatch: expected %h, got %h", $time, what, want, got);
        o_err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_composite want;
        if (!i_rst_n) begin
            cfg_cols = bmc_pkg::COLS_RESET;
            cfg_rows = bmc_pkg::ROWS_RESET;
            cfg_overlay_en = 1'b0;
            cfg_scale = bmc_pkg::SCALE_RESET;
            pixels_due.delete();
            o_err_cnt = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    bmc_pkg::REG_DEPTH_COLS:     cfg_cols = i_pwdata[9:0];
                    bmc_pkg::REG_DEPTH_ROWS:     cfg_rows = i_pwdata[9:0];
                    bmc_pkg::REG_OVERLAY_ENABLE: cfg_overlay_en = i_pwdata[0];
                    bmc_pkg::REG_OVERLAY_SCALE:  cfg_scale = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == bmc_pkg::CMD_LOAD)
                    body_labels[i_s_tdata[17:0]] = i_s_tdata[25:18];
                else
                    pixels_due.push_back(predict_composite(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pixels_due.size() == 0)
                    report_mismatch("unexpected beat", 24'h0, i_m_tdata);
                else begin
                    want = pixels_due.pop_front();
                    if (i_m_tdata !== want.pixel)
                        report_mismatch("out_pixel", want.pixel, i_m_tdata);
                    if (i_m_tuser !== want.person)
                        report_mismatch("is_person", {23'd0, want.person},
                                        {23'd0, i_m_tuser});
                end
            end
        end
        o_pending = pixels_due.size();
    end

endmodule

`default_nettype wire

### dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus for the body mask compositor: a short directed set of frame
// edges, invalid coordinates and blend extremes, then random loads and
// composites over several frame sizes and blend scales. Both stream sides
// idle at random; a separate checker predicts and compares every beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DRAIN_CYCLES    = 16;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic         m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    int err_cnt;
    int pending;
    int cycle_cnt = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    // frame size as last programmed, used to aim coordinates
    logic [9:0] frame_cols = bmc_pkg::COLS_RESET;
    logic [9:0] frame_rows = bmc_pkg::ROWS_RESET;
    bit         written_map [0:bmc_pkg::BODY_STORE_DEPTH_DEF-1];

    int phase_cols  [NUM_PHASES] = '{512, 64, 1023, 1, 300, 1023, 1, 40, 0, 512};
    int phase_rows  [NUM_PHASES] = '{424, 48, 1023, 1, 200, 1, 1023, 30, 10, 0};
    int phase_en    [NUM_PHASES] = '{0, 1, 1, 1, 1, 1, 1, 1, 0, 1};
    int phase_scale [NUM_PHASES] = '{256, 256, 128, 2, 3, 65535, 255, 0, 1, 0};

    body_mask_compositor dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    body_mask_checker u_result_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_err_cnt  (err_cnt),
        .o_pending  (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // tvalid stays high from one beat to the next unless an idle cycle is drawn
    task automatic send_beat(input logic cmd, input logic [143:0] beat);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= beat;
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        // loads produce no beat, let the last store write settle
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_label();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return 8'($urandom_range(5));
        else if (sel < 75)
            return 8'd255;
        return 8'($urandom_range(254, 6));
    endfunction

    function automatic logic [23:0] pick_color();
        int sel;
        sel = $urandom_range(99);
        if (sel < 10)
            return 24'h000000;
        else if (sel < 20)
            return 24'hFFFFFF;
        return 24'($urandom);
    endfunction

    function automatic logic [31:0] pick_overlay();
        int sel;
        logic [31:0] ovl;
        sel = $urandom_range(99);
        ovl = $urandom;
        if (sel < 20)
            ovl[31:24] = 8'h00;
        else if (sel < 40)
            ovl[31:24] = 8'hFF;
        return ovl;
    endfunction

    // one Q11.4 coordinate against a frame span of 'span' pixels
    function automatic logic [15:0] pick_coord(input int unsigned span);
        int sel;
        int unsigned near_edge;
        sel = $urandom_range(99);
        if (span != 0 && sel < 65)
            return {1'b0, 11'($urandom_range(span - 1)), 4'($urandom)};
        if (sel < 75) begin
            near_edge = span + $urandom_range(1) - 1;
            return {1'b0, 11'(near_edge), 4'($urandom)};
        end
        if (sel < 85)
            return 16'h8000;
        if (sel < 90)
            return 16'(-int'($urandom_range(64, 1)));
        return 16'($urandom);
    endfunction

    task automatic send_load(input logic [17:0] addr, input logic [7:0] label);
        send_beat(bmc_pkg::CMD_LOAD, {6'd0, 32'($urandom), 24'($urandom), 24'($urandom),
                                      16'($urandom), 16'($urandom), label, addr});
        written_map[addr] = 1'b1;
    endtask

    // loads the addressed label first if it was never written
    task automatic send_composite(input logic [15:0] x, input logic [15:0] y,
                                  input logic [23:0] cam, input logic [23:0] bg,
                                  input logic [31:0] ovl);
        int unsigned col, row, addr;
        if (!x[15] && !y[15]) begin
            col = x[14:4];
            row = y[14:4];
            if (col < frame_cols && row < frame_rows) begin
                addr = row * frame_cols + col;
                if (addr < bmc_pkg::BODY_STORE_DEPTH_DEF && !written_map[addr])
                    send_load(addr[17:0], pick_label());
            end
        end
        send_beat(bmc_pkg::CMD_COMPOSITE,
                  {6'd0, ovl, bg, cam, y, x, 8'($urandom), 18'($urandom)});
    endtask

    task automatic send_random_item();
        int unsigned addr;
        if ($urandom_range(99) < 20) begin
            if (frame_cols != 0 && frame_rows != 0 && $urandom_range(1) == 1)
                addr = $urandom_range(frame_rows - 1) * frame_cols
                       + $urandom_range(frame_cols - 1);
            else
                addr = $urandom;
            send_load(addr[17:0], pick_label());
        end else
            send_composite(pick_coord(frame_cols), pick_coord(frame_rows),
                           pick_color(), pick_color(), pick_overlay());
    endtask

    task automatic configure(input int cols, input int rows, input int en, input int scale);
        quiesce();
        apb_write(bmc_pkg::REG_DEPTH_COLS, 32'(cols));
        apb_write(bmc_pkg::REG_DEPTH_ROWS, 32'(rows));
        apb_write(bmc_pkg::REG_OVERLAY_ENABLE, 32'(en));
        apb_write(bmc_pkg::REG_OVERLAY_SCALE, 32'(scale));
        frame_cols = 10'(cols);
        frame_rows = 10'(rows);
    endtask

    // reset frame of 512 x 424, no overlay
    task automatic run_frame_edges();
        send_load(18'd0, 8'd0);
        send_composite(16'h0000, 16'h0000, 24'h000000, 24'hFFFFFF, 32'h0);
        send_load(18'd1, 8'd5);
        send_composite(16'h001F, 16'h0000, 24'hFFFFFF, 24'h000000, 32'hFFFFFFFF);
        send_load(18'd2, 8'd6);
        send_composite(16'h0020, 16'h000F, 24'h123456, 24'h654321, 32'h0);
        // last pixel of the frame, and its left neighbor
        send_load(18'd217087, 8'd255);
        send_composite(16'd8191, 16'd6783, 24'hFFFFFF, 24'h000000, 32'h0);
        send_load(18'd217086, 8'd3);
        send_composite(16'd8160, 16'd6768, 24'hA5A5A5, 24'h5A5A5A, 32'h0);
        // one past the last column and the last row
        send_composite(16'd8192, 16'h0000, 24'hFFFFFF, 24'h000000, 32'h0);
        send_composite(16'h0000, 16'd6784, 24'hFFFFFF, 24'h000000, 32'h0);
        // invalid mark, other negatives, largest positive
        send_composite(16'h8000, 16'h0000, 24'hFFFFFF, 24'h000000, 32'h0);
        send_composite(16'h0000, 16'h8000, 24'hFFFFFF, 24'h000000, 32'h0);
        send_composite(16'hFFFF, 16'h0005, 24'hFFFFFF, 24'h000000, 32'h0);
        send_composite(16'h7FFF, 16'h7FFF, 24'hFFFFFF, 24'h000000, 32'h0);
        send_load(18'h3FFFF, 8'd0);
        send_load(18'h3FFFE, 8'd255);
    endtask

    // scale 1.0, pixel 0 holds a person label
    task automatic run_blend_edges();
        send_composite(16'h0000, 16'h0000, 24'hFFFFFF, 24'h000000, 32'h00FFFFFF);
        send_composite(16'h0000, 16'h0000, 24'hFFFFFF, 24'h000000, 32'hFFFFFFFF);
        send_composite(16'h0000, 16'h0000, 24'hFFFFFF, 24'h000000, 32'hFF000000);
        send_composite(16'h0000, 16'h0000, 24'h000000, 24'hFFFFFF, 32'h80FF00FF);
    endtask

    initial begin
        phase_scale[7] = $urandom_range(65534, 257);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0)
                configure(phase_cols[phase], phase_rows[phase], phase_en[phase],
                          phase_scale[phase]);
            if (phase < 3) begin
                tx_idle_pct = 16;
                rx_stall_pct = 48;
            end else if (phase < 6) begin
                tx_idle_pct = 48;
                rx_stall_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            if (phase == 0)
                run_frame_edges();
            if (phase == 1)
                run_blend_edges();
            repeat (ITEMS_PER_PHASE) send_random_item();
        end
        quiesce();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
